[hw/rtl/pid_pkg.sv]
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants of the PID update block
// Fixed field widths, datapath widths of the shared multiplier and the
// divider, register indexes and the control word of the multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pid_pkg;

    // field widths
    localparam int DATA_W     = 16;              // target, sensed, drive (Q3.12)
    localparam int DT_W       = 16;              // step_time (Q0.16)
    localparam int GAIN_W     = 16;              // gains (Q8.8)
    localparam int LIM_W      = 15;              // limits (Q3.12)
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int ACC_WIDTH_DEF = 32;

    // derived datapath widths
    localparam int ERR_W   = DATA_W + 1;         // error, Q4.12
    localparam int DELTA_W = ERR_W + 1;          // change in error
    localparam int NUM_W   = DELTA_W - 1 + DT_W; // |delta| << 16
    localparam int DERIV_W = 32;                 // saturated derivative
    localparam int LO_W    = 16;                 // low half of the integral

    // shared multiplier: 17 bit signed by 33 bit signed
    localparam int MA_W   = GAIN_W + 1;
    localparam int MB_W   = DERIV_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int SUM_W  = PROD_W + 2;

    // rounding of the Q.20 sum down to Q.12
    localparam int FRAC_DROP  = 8;
    localparam int ROUND_HALF = 128;
    localparam int Y_W        = SUM_W - FRAC_DROP;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT   = 3'd4;

    // control word of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul;       // register a * b
        logic acc_load;  // load accumulator with the product term
        logic acc_add;   // add the product term to the accumulator
        logic shift16;   // product term is the product >>> 16
    } t_mac_ctl;

endpackage

`default_nettype wire

[hw/rtl/pid_controller_update.sv]
// ----------------------------------------------------------------------------
// pid_controller_update: PID update with anti-windup clamp
// Flow: an accepted item waits for the serial divide of the error change
//   by step_time; at zero step_time it goes straight to the final step.
// A new item is accepted only once the last one is handed over; a drive
//   item left waiting holds the next one in its final step.
// Reset (synchronous, active low) clears gains, limits, integral, last error,
//   held drive and the output register; ready rises in the cycle after reset ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_update import pid_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input item channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [DATA_W-1:0]     i_target,
    input  wire logic signed [DATA_W-1:0]     i_sensed,
    input  wire logic [DT_W-1:0]              i_step_time,
    // result item channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [DATA_W-1:0]          o_drive,
    output logic                              o_clamped,
    // configuration write channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // integral update width: accumulator or exact error * dt, plus carry
    localparam int EDT_W     = ERR_W + DT_W + 1;
    localparam int INT_SUM_W = ((ACC_WIDTH > EDT_W) ? ACC_WIDTH : EDT_W) + 1;
    localparam int HI_W      = ACC_WIDTH - LO_W;

    localparam logic signed [INT_SUM_W-1:0] ACC_MAX =
        INT_SUM_W'((64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1);
    localparam logic signed [INT_SUM_W-1:0] ACC_MIN =
        INT_SUM_W'(-(64'sd1 <<< (ACC_WIDTH - 1)));
    localparam logic signed [NUM_W:0] DERIV_MAX =
        (NUM_W + 1)'((64'sd1 <<< (DERIV_W - 1)) - 64'sd1);
    localparam logic signed [NUM_W:0] DERIV_MIN =
        (NUM_W + 1)'(-(64'sd1 <<< (DERIV_W - 1)));
    localparam logic signed [Y_W-1:0] DRV_MAX =
        Y_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [Y_W-1:0] DRV_MIN =
        Y_W'(-(64'sd1 <<< (DATA_W - 1)));

    // Sequencer: every product goes through the one shared multiplier,
    // while the divider works out the derivative in the background.
    typedef enum logic [3:0] {
        S_IDLE,       // wait for an item
        S_INT_MUL,    // error * dt
        S_INT_ADD,    // integral += product, saturate
        S_INT_CLAMP,  // symmetric integral clamp
        S_P_MUL,      // prop_gain * error
        S_IH_MUL,     // integ_gain * integral high part, load P term
        S_IL_MUL,     // integ_gain * integral low part, add high term
        S_IL_ADD,     // add low term >>> 16
        S_DIV_WAIT,   // wait for the quotient, saturate derivative
        S_D_MUL,      // deriv_gain * derivative
        S_D_ADD,      // add D term
        S_ROUND,      // round Q.20 down to Q.12
        S_EMIT        // clamp, saturate and hand over the result
    } t_state;

    t_state r_state;

    // configuration and persistent state
    logic [GAIN_W-1:0]          r_prop;
    logic [GAIN_W-1:0]          r_igain;
    logic [GAIN_W-1:0]          r_dgain;
    logic [LIM_W-1:0]           r_ilim;
    logic [LIM_W-1:0]           r_olim;
    logic signed [ERR_W-1:0]    r_last_err;
    logic signed [ACC_WIDTH-1:0] r_integ;
    logic signed [DATA_W-1:0]   r_held;

    // handshake and output registers
    logic                       r_in_ready;
    logic                       r_cfg_ready;
    logic                       r_out_valid;
    logic signed [DATA_W-1:0]   r_drive;
    logic                       r_clamped;

    // per-item working registers
    logic signed [ERR_W-1:0]    r_err;
    logic [DT_W-1:0]            r_dt;
    logic                       r_neg;
    logic                       r_zero;
    logic signed [DERIV_W-1:0]  r_deriv;
    logic signed [Y_W-1:0]      r_y;

    logic in_acc;
    logic cfg_acc;
    logic out_free;

    // accept-time arithmetic
    logic signed [ERR_W-1:0]    err_c;
    logic signed [DELTA_W-1:0]  delta_c;
    logic [DELTA_W-2:0]         dabs_c;
    logic [NUM_W-1:0]           div_num;
    logic                       div_start;
    logic                       div_done;
    logic [NUM_W-1:0]           div_quo;

    // shared multiplier
    t_mac_ctl                   mac_ctl;
    logic signed [MA_W-1:0]     mac_a;
    logic signed [MB_W-1:0]     mac_b;
    logic signed [PROD_W-1:0]   mac_prod;
    logic signed [SUM_W-1:0]    mac_acc;

    // next values
    logic signed [INT_SUM_W-1:0] int_sum;
    logic signed [ACC_WIDTH-1:0] n_integ_sat;
    logic signed [INT_SUM_W-1:0] integ_w;
    logic signed [INT_SUM_W-1:0] ilim_w;
    logic signed [ACC_WIDTH-1:0] n_integ_clamp;
    logic signed [HI_W-1:0]      integ_hi;
    logic signed [NUM_W:0]       quo_s;
    logic signed [DERIV_W-1:0]   n_deriv;
    logic signed [SUM_W-1:0]     sum_rnd;
    logic signed [Y_W-1:0]       olim_w;
    logic signed [Y_W-1:0]       y_c;
    logic signed [DATA_W-1:0]    n_drive;
    logic                        n_clip;

    assign in_acc   = i_in_valid && r_in_ready;
    assign cfg_acc  = i_cfg_valid && r_cfg_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // error and its change against the previous item
    assign err_c   = ERR_W'(i_target) - ERR_W'(i_sensed);
    assign delta_c = DELTA_W'(err_c) - DELTA_W'(r_last_err);
    assign dabs_c  = delta_c[DELTA_W-1] ? (DELTA_W - 1)'(-delta_c)
                                        : (DELTA_W - 1)'(delta_c);
    assign div_num   = {dabs_c, {DT_W{1'b0}}};
    assign div_start = in_acc && (i_step_time != '0);

    pid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (i_step_time),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Split the integral as hi * 2^16 + lo so that every product fits the
    // multiplier; gain * lo >>> 16 restores the floor of the full product.
    assign integ_hi = r_integ[ACC_WIDTH-1:LO_W];

    always_comb begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (r_state)
            S_INT_MUL: begin
                mac_ctl.mul = 1'b1;
                mac_a       = r_err;
                mac_b       = MB_W'($signed({1'b0, r_dt}));
            end
            S_P_MUL: begin
                mac_ctl.mul = 1'b1;
                mac_a       = $signed({1'b0, r_prop});
                mac_b       = MB_W'(r_err);
            end
            S_IH_MUL: begin
                mac_ctl.mul      = 1'b1;
                mac_ctl.acc_load = 1'b1;
                mac_a            = $signed({1'b0, r_igain});
                mac_b            = MB_W'(integ_hi);
            end
            S_IL_MUL: begin
                mac_ctl.mul     = 1'b1;
                mac_ctl.acc_add = 1'b1;
                mac_a           = $signed({1'b0, r_igain});
                mac_b           = MB_W'($signed({1'b0, r_integ[LO_W-1:0]}));
            end
            S_IL_ADD: begin
                mac_ctl.acc_add = 1'b1;
                mac_ctl.shift16 = 1'b1;
            end
            S_D_MUL: begin
                mac_ctl.mul = 1'b1;
                mac_a       = $signed({1'b0, r_dgain});
                mac_b       = MB_W'(r_deriv);
            end
            S_D_ADD: begin
                mac_ctl.acc_add = 1'b1;
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    pid_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_prod (mac_prod),
        .o_acc  (mac_acc)
    );

    // integral += error * dt, saturated to the accumulator range
    assign int_sum = INT_SUM_W'(r_integ) + INT_SUM_W'(mac_prod);

    always_comb begin
        if (int_sum > ACC_MAX) begin
            n_integ_sat = ACC_WIDTH'(ACC_MAX);
        end else if (int_sum < ACC_MIN) begin
            n_integ_sat = ACC_WIDTH'(ACC_MIN);
        end else begin
            n_integ_sat = ACC_WIDTH'(int_sum);
        end
    end

    // anti-windup: clamp to +-(integ_limit << 16) when the limit is set
    assign integ_w = INT_SUM_W'(r_integ);
    assign ilim_w  = INT_SUM_W'({r_ilim, {LO_W{1'b0}}});

    always_comb begin
        n_integ_clamp = r_integ;
        if (r_ilim != '0) begin
            if (integ_w > ilim_w) begin
                n_integ_clamp = ACC_WIDTH'(ilim_w);
            end else if (integ_w < -ilim_w) begin
                n_integ_clamp = ACC_WIDTH'(-ilim_w);
            end
        end
    end

    // signed quotient, saturated to the derivative width
    assign quo_s = r_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    always_comb begin
        if (quo_s > DERIV_MAX) begin
            n_deriv = DERIV_W'(DERIV_MAX);
        end else if (quo_s < DERIV_MIN) begin
            n_deriv = DERIV_W'(DERIV_MIN);
        end else begin
            n_deriv = DERIV_W'(quo_s);
        end
    end

    // round half up from Q.20 to Q.12
    assign sum_rnd = mac_acc + SUM_W'(ROUND_HALF);

    // output clamp, then range saturation; either one flags the item
    assign olim_w = Y_W'(r_olim);

    always_comb begin
        n_clip = 1'b0;
        y_c    = r_y;
        if (r_olim != '0) begin
            if (r_y > olim_w) begin
                y_c    = olim_w;
                n_clip = 1'b1;
            end else if (r_y < -olim_w) begin
                y_c    = -olim_w;
                n_clip = 1'b1;
            end
        end
        if (y_c > DRV_MAX) begin
            y_c    = DRV_MAX;
            n_clip = 1'b1;
        end else if (y_c < DRV_MIN) begin
            y_c    = DRV_MIN;
            n_clip = 1'b1;
        end
        n_drive = DATA_W'(y_c);
    end

    // sequencer, persistent state, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_cfg_ready <= 1'b0;
            r_out_valid <= 1'b0;
            r_drive     <= '0;
            r_clamped   <= 1'b0;
            r_prop      <= '0;
            r_igain     <= '0;
            r_dgain     <= '0;
            r_ilim      <= '0;
            r_olim      <= '0;
            r_last_err  <= '0;
            r_integ     <= '0;
            r_held      <= '0;
        end else begin
            r_cfg_ready <= 1'b1;

            // drop the result once taken; a new one below overrides
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_in_ready <= !in_acc;
                    if (in_acc) begin
                        if (i_step_time == '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_last_err <= err_c;
                            r_state    <= S_INT_MUL;
                        end
                    end
                end
                S_INT_MUL: begin
                    r_state <= S_INT_ADD;
                end
                S_INT_ADD: begin
                    r_integ <= n_integ_sat;
                    r_state <= S_INT_CLAMP;
                end
                S_INT_CLAMP: begin
                    r_integ <= n_integ_clamp;
                    r_state <= S_P_MUL;
                end
                S_P_MUL: begin
                    r_state <= S_IH_MUL;
                end
                S_IH_MUL: begin
                    r_state <= S_IL_MUL;
                end
                S_IL_MUL: begin
                    r_state <= S_IL_ADD;
                end
                S_IL_ADD: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= S_D_MUL;
                    end
                end
                S_D_MUL: begin
                    r_state <= S_D_ADD;
                end
                S_D_ADD: begin
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold here until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_zero) begin
                            r_drive   <= r_held;
                            r_clamped <= 1'b0;
                        end else begin
                            r_drive   <= n_drive;
                            r_clamped <= n_clip;
                            r_held    <= n_drive;
                        end
                        r_in_ready <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // gain writes restart the integral; limit writes keep it
            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_PROP_GAIN: begin
                        r_prop  <= i_cfg_data[GAIN_W-1:0];
                        r_integ <= '0;
                    end
                    CFG_INTEG_GAIN: begin
                        r_igain <= i_cfg_data[GAIN_W-1:0];
                        r_integ <= '0;
                    end
                    CFG_DERIV_GAIN: begin
                        r_dgain <= i_cfg_data[GAIN_W-1:0];
                        r_integ <= '0;
                    end
                    CFG_INTEG_LIMIT: begin
                        r_ilim <= i_cfg_data[LIM_W-1:0];
                    end
                    CFG_OUT_LIMIT: begin
                        r_olim <= i_cfg_data[LIM_W-1:0];
                    end
                    default: begin
                        r_ilim <= r_ilim;
                    end
                endcase
            end
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err  <= err_c;
            r_dt   <= i_step_time;
            r_neg  <= delta_c[DELTA_W-1];
            r_zero <= (i_step_time == '0);
        end
        if (r_state == S_DIV_WAIT && div_done) begin
            r_deriv <= n_deriv;
        end
        if (r_state == S_ROUND) begin
            r_y <= sum_rnd[SUM_W-1:FRAC_DROP];
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_cfg_ready = r_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_clamped   = r_clamped;

endmodule

`default_nettype wire

[hw/rtl/pid_mac.sv]
// ----------------------------------------------------------------------------
// pid_mac: shared multiply-accumulate unit
// One registered signed multiplier and a wide accumulator fed from it.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_mac import pid_pkg::*; (
    input  wire logic                     i_clk,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [MA_W-1:0]   i_a,
    input  wire logic signed [MB_W-1:0]   i_b,
    output logic signed [PROD_W-1:0]      o_prod,
    output logic signed [SUM_W-1:0]       o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] term;
    logic signed [SUM_W-1:0]  term_ext;

    assign prod_c   = PROD_W'(i_a) * PROD_W'(i_b);
    assign term     = i_ctl.shift16 ? (r_prod >>> LO_W) : r_prod;
    assign term_ext = SUM_W'(term);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= prod_c;
        end
        if (i_ctl.acc_load) begin
            r_acc <= term_ext;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + term_ext;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

[hw/rtl/pid_div.sv]
// ----------------------------------------------------------------------------
// pid_div: serial restoring divider
// One quotient bit per cycle; unsigned NUM_W bit dividend by DT_W bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_div import pid_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DT_W-1:0]    i_den,
    output logic                    o_done,
    output logic [NUM_W-1:0]        o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DT_W-1:0]  r_rem;
    logic [DT_W-1:0]  r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DT_W:0]    trial;
    logic             ge;
    logic [DT_W-1:0]  n_rem;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign n_rem = ge ? DT_W'(trial - {1'b0, r_den}) : trial[DT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // shift the dividend out and the quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

`default_nettype wire

[hw/rtl/pid_chk.sv]
// ----------------------------------------------------------------------------
// pid_chk: port-level checks of the PID update block
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_chk import pid_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       o_in_ready,
    input  wire logic [DT_W-1:0]            i_step_time,
    input  wire logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    input  wire logic signed [DATA_W-1:0]   o_drive,
    input  wire logic                       o_clamped
);

    // a pending result item stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result item dropped before it was taken");

    // a timed item keeps the block busy on the next cycle
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_step_time != '0)) |=> !o_in_ready)
        else $error("ready stayed high after a timed item");

    // reset empties the output register and closes the input
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_ready))
        else $error("output valid or input ready after reset");

    // a clamped drive sits at a nonzero limit
    a_clamp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clamped) |-> (o_drive != '0))
        else $error("clamped flag on a zero drive");

endmodule

bind pid_controller_update pid_chk u_pid_chk (.*);

`default_nettype wire
